>>> src/msp_pkg.sv
// Package: request/response types, opcodes and controller states for the shared stack pool.
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

   localparam int DATA_W = 32;
   localparam int SID_W  = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic signed [DATA_W-1:0] POP_EMPTY_VALUE = -32'sd1;
   localparam logic signed [DATA_W-1:0] PUSH_VALUE_OUT  = 32'sd0;

   typedef struct packed {
      logic                     opcode;
      logic [SID_W-1:0]         stack_id;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] pop_value;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP_HEAD,
      ST_POP_SLOT
   } state_type;

endpackage

`default_nettype wire

>>> src/msp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module msp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> src/multi_stack_shared_pool.sv
// Top level: several linked stacks sharing one slot pool with a free list, memory based.
//
//   channel   ports                       handshake
//   request   req_item (req_type)         accepted when start && !busy
//   response  rsp_item (rsp_type)         one cycle, marked by rsp_valid
//
// Push: head/link read, then write back. Pop: head read, slot read, write back;
// a pop of an empty stack ends after the head read. The dependent head-then-slot
// read through the registered-read memories sets these steps. The response appears
// the cycle after the last step; a new request may be accepted in that cycle.
// Reset is synchronous; after it the block is ready at once: stack heads use
// per-stack valid bits and untouched slots use a fill count. The receiver
// cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module multi_stack_shared_pool
   import msp_pkg::*;
#(
   parameter int NUM_STACKS = 4,
   parameter int POOL_DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   localparam int LW = $clog2(POOL_DEPTH + 1);
   localparam int AW = $clog2(POOL_DEPTH);
   localparam int HW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int SW = DATA_W + LW;
   localparam logic [LW-1:0] LINK_NULL = LW'(POOL_DEPTH);

   state_type                state_ff, state_in;
   logic [SID_W-1:0]         sid_ff, sid_in;
   logic                     sid_ok_ff, sid_ok_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [LW-1:0]            free_head_ff, free_head_in;
   logic [LW-1:0]            fresh_ff, fresh_in;
   logic [LW-1:0]            pop_slot_ff, pop_slot_in;
   logic [NUM_STACKS-1:0]    head_valid_ff, head_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic            head_wr_en;
   logic [HW-1:0]   head_wr_addr, head_rd_addr;
   logic [LW-1:0]   head_wr_data, head_rd_data;
   logic            slot_wr_en;
   logic [AW-1:0]   slot_wr_addr, slot_rd_addr;
   logic [SW-1:0]   slot_wr_data, slot_rd_data;

   logic [HW-1:0]   sid_idx;
   logic [LW-1:0]   head_eff;
   logic [LW-1:0]   stored_link;
   logic [DATA_W-1:0] stored_data;

   // Slots at or above the fill count were never written: their link is slot+1.
   function automatic logic [LW-1:0] eff_link(input logic [LW-1:0] slot,
                                              input logic [LW-1:0] stored,
                                              input logic [LW-1:0] fresh);
      logic [LW-1:0] result;
      if (slot >= fresh) begin
         result = slot + LW'(1);
      end else begin
         result = stored;
      end
      return result;
   endfunction

   msp_ram #(.WIDTH(LW), .DEPTH(NUM_STACKS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_addr (head_rd_addr),
      .rd_data (head_rd_data)
   );

   msp_ram #(.WIDTH(SW), .DEPTH(POOL_DEPTH)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   assign sid_idx     = HW'(sid_ff);
   assign head_eff    = head_valid_ff[sid_idx] ? head_rd_data : LINK_NULL;
   assign stored_link = slot_rd_data[LW-1:0];
   assign stored_data = slot_rd_data[SW-1:LW];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= '0;
         fresh_ff      <= '0;
         head_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         fresh_ff      <= fresh_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sid_ff      <= sid_in;
      sid_ok_ff   <= sid_ok_in;
      val_ff      <= val_in;
      pop_slot_ff <= pop_slot_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      sid_in        = sid_ff;
      sid_ok_in     = sid_ok_ff;
      val_in        = val_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      pop_slot_in   = pop_slot_ff;
      head_valid_in = head_valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      head_wr_en    = 1'b0;
      head_wr_addr  = sid_idx;
      head_wr_data  = free_head_ff;
      head_rd_addr  = HW'(req_item.stack_id);
      slot_wr_en    = 1'b0;
      slot_wr_addr  = AW'(free_head_ff);
      slot_wr_data  = {val_ff, head_eff};
      slot_rd_addr  = AW'(free_head_ff);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sid_in    = req_item.stack_id;
               sid_ok_in = 32'(req_item.stack_id) < NUM_STACKS;
               val_in    = req_item.push_value;
               state_in  = (req_item.opcode == OP_PUSH) ? ST_PUSH : ST_POP_HEAD;
            end
         end
         ST_PUSH: begin
            rsp_valid_in     = 1'b1;
            rsp_in.ok        = 1'b0;
            rsp_in.pop_value = PUSH_VALUE_OUT;
            if (sid_ok_ff && (free_head_ff < LINK_NULL)) begin
               rsp_in.ok              = 1'b1;
               slot_wr_en             = 1'b1;
               head_wr_en             = 1'b1;
               head_valid_in[sid_idx] = 1'b1;
               free_head_in = eff_link(free_head_ff, stored_link, fresh_ff);
               if (free_head_ff >= fresh_ff) begin
                  fresh_in = free_head_ff + LW'(1);
               end
            end
            state_in = ST_IDLE;
         end
         ST_POP_HEAD: begin
            slot_rd_addr = AW'(head_eff);
            pop_slot_in  = head_eff;
            if (sid_ok_ff && (head_eff < LINK_NULL)) begin
               state_in = ST_POP_SLOT;
            end else begin
               rsp_valid_in     = 1'b1;
               rsp_in.ok        = 1'b0;
               rsp_in.pop_value = POP_EMPTY_VALUE;
               state_in         = ST_IDLE;
            end
         end
         ST_POP_SLOT: begin
            head_wr_en       = 1'b1;
            head_wr_data     = eff_link(pop_slot_ff, stored_link, fresh_ff);
            slot_wr_en       = 1'b1;
            slot_wr_addr     = AW'(pop_slot_ff);
            slot_wr_data     = {stored_data, free_head_ff};
            free_head_in     = pop_slot_ff;
            rsp_valid_in     = 1'b1;
            rsp_in.ok        = 1'b1;
            rsp_in.pop_value = stored_data;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) != ST_IDLE))
      else $error("response without a finished operation");

   a_free_below_fill: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= fresh_ff)
      else $error("free head beyond the fill count");

   a_pop_slot_real: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_SLOT) |-> (pop_slot_ff < LINK_NULL))
      else $error("pop write-back of a null slot");

endmodule

`default_nettype wire

>>> sim/stack_pool_checker.sv
// Watches the request/response channels of the shared stack pool, predicts responses, compares.
`timescale 1ns / 1ps

module stack_pool_checker
   import msp_pkg::*;
#(
   parameter int NUM_STACKS = 4,
   parameter int POOL_DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_item,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_item,
   output int           pending,
   output int           fail_count,
   output int           rsp_count,
   output int           full_count,
   output int           empty_count,
   output int           peak_used
);

   localparam int LINK_W = $clog2(POOL_DEPTH) + 1;
   localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(POOL_DEPTH);

   logic signed [DATA_W-1:0] slot_value [POOL_DEPTH];
   logic [LINK_W-1:0]        slot_next  [POOL_DEPTH];
   logic [LINK_W-1:0]        top_slot   [NUM_STACKS];
   logic [LINK_W-1:0]        free_slot;
   int                       used_slots;
   rsp_type                  predicted_rsp [$];

   function automatic void clear_pool();
      for (int i = 0; i < POOL_DEPTH; i++) begin
         slot_value[i] = '0;
         slot_next[i]  = (i == POOL_DEPTH - 1) ? LINK_NIL : LINK_W'(i + 1);
      end
      for (int i = 0; i < NUM_STACKS; i++)
         top_slot[i] = LINK_NIL;
      free_slot  = '0;
      used_slots = 0;
   endfunction

   function automatic rsp_type apply_stack_op(input req_type r);
      rsp_type           res;
      logic [LINK_W-1:0] s;
      logic [LINK_W-2:0] si;
      res.ok = 1'b0;
      if (r.opcode == OP_PUSH) begin
         res.pop_value = PUSH_VALUE_OUT;
         if (int'(r.stack_id) < NUM_STACKS) begin
            if (free_slot >= LINK_NIL) begin
               full_count++;
            end else begin
               s                  = free_slot;
               si                 = s[LINK_W-2:0];
               free_slot          = slot_next[si];
               slot_value[si]     = r.push_value;
               slot_next[si]      = top_slot[r.stack_id];
               top_slot[r.stack_id] = s;
               res.ok             = 1'b1;
               used_slots++;
               if (used_slots > peak_used)
                  peak_used = used_slots;
            end
         end
      end else begin
         res.pop_value = POP_EMPTY_VALUE;
         if (int'(r.stack_id) < NUM_STACKS) begin
            s = top_slot[r.stack_id];
            if (s >= LINK_NIL) begin
               empty_count++;
            end else begin
               si                   = s[LINK_W-2:0];
               top_slot[r.stack_id] = slot_next[si];
               slot_next[si]        = free_slot;
               free_slot            = s;
               res.ok               = 1'b1;
               res.pop_value        = slot_value[si];
               used_slots--;
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input rsp_type exp, input rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected ok=%0b value=%0d, got ok=%0b value=%0d",
                  $time, what, exp.ok, exp.pop_value, got.ok, got.pop_value);
   endtask

   always @(posedge clock) begin
      rsp_type exp;
      if (reset) begin
         clear_pool();
         predicted_rsp.delete();
         fail_count  = 0;
         rsp_count   = 0;
         full_count  = 0;
         empty_count = 0;
         peak_used   = 0;
      end else begin
         if (rsp_valid) begin
            rsp_count++;
            if (predicted_rsp.size() == 0) begin
               exp = '0;
               report_mismatch("response with no request outstanding", exp, rsp_item);
            end else begin
               exp = predicted_rsp.pop_front();
               if (rsp_item.ok !== exp.ok)
                  report_mismatch("ok flag mismatch", exp, rsp_item);
               if (rsp_item.pop_value !== exp.pop_value)
                  report_mismatch("pop value mismatch", exp, rsp_item);
            end
         end
         if (start && !busy)
            predicted_rsp.push_back(apply_stack_op(req_item));
      end
      pending = predicted_rsp.size();
   end

endmodule

>>> sim/multi_stack_shared_pool_test.sv
// Testbench top: drives push/pop requests into the shared stack pool and reports the verdict.
`timescale 1ns / 1ps

module multi_stack_shared_pool_test;
   import msp_pkg::*;

   localparam int NUM_STACKS     = 4;
   localparam int POOL_DEPTH     = 16;
   localparam int TOTAL_ITEMS    = 1100;
   localparam int DIRECTED_ITEMS = 25;
   localparam int RANDOM_ITEMS   = TOTAL_ITEMS - DIRECTED_ITEMS;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic signed [DATA_W-1:0] CORNERS [4] =
      '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1};

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   int pending;
   int fail_count;
   int rsp_count;
   int full_count;
   int empty_count;
   int peak_used;
   int sent;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   multi_stack_shared_pool #(
      .NUM_STACKS(NUM_STACKS),
      .POOL_DEPTH(POOL_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   stack_pool_checker #(
      .NUM_STACKS(NUM_STACKS),
      .POOL_DEPTH(POOL_DEPTH)
   ) pool_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .pending    (pending),
      .fail_count (fail_count),
      .rsp_count  (rsp_count),
      .full_count (full_count),
      .empty_count(empty_count),
      .peak_used  (peak_used)
   );

   // returns at the edge where the request is taken
   task automatic send_op(input logic op, input logic [SID_W-1:0] sid,
                          input logic signed [DATA_W-1:0] val);
      req_type r;
      r.opcode     = op;
      r.stack_id   = sid;
      r.push_value = val;
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   task automatic maybe_idle();
      if ($urandom_range(99) < 23) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
   endtask

   initial begin
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("Watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int                       push_bias;
      int                       focus;
      logic                     op;
      logic [SID_W-1:0]         sid;
      logic signed [DATA_W-1:0] val;

      sent     = 0;
      start    = 1'b0;
      req_item = '0;
      reset    = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty pops, fill the pool with corner values, overflow, then pop each stack
      for (int s = 0; s < NUM_STACKS; s++)
         send_op(OP_POP, SID_W'(s), $urandom);
      for (int i = 0; i < POOL_DEPTH; i++)
         send_op(OP_PUSH, SID_W'(i % NUM_STACKS), CORNERS[2'((i + i / 4) % 4)]);
      send_op(OP_PUSH, SID_W'(2), 32'sh5A5A_5A5A);
      for (int s = 0; s < NUM_STACKS; s++)
         send_op(OP_POP, SID_W'(s), $urandom);
      drain();

      push_bias = 50;
      focus     = NUM_STACKS;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 120 == 0) begin
            case ($urandom_range(4))
               0: push_bias = 85;
               1: push_bias = 15;
               2: push_bias = 65;
               3: push_bias = 35;
               default: push_bias = 50;
            endcase
            focus = $urandom_range(NUM_STACKS);
         end
         op = ($urandom_range(99) < push_bias) ? OP_PUSH : OP_POP;
         if (focus < NUM_STACKS && $urandom_range(3) != 0)
            sid = SID_W'(focus);
         else
            sid = SID_W'($urandom_range(NUM_STACKS - 1));
         val = ($urandom_range(9) == 0) ? CORNERS[2'($urandom_range(3))] : $urandom;
         send_op(op, sid, val);
         if (n == RANDOM_ITEMS / 2)
            drain();
         else if (n < 300 || n >= 500)
            maybe_idle();
      end

      drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d requests over %0d stacks sharing %0d slots; %0d responses checked.",
               sent, NUM_STACKS, POOL_DEPTH, rsp_count);
      $display("Pushes refused on a full pool: %0d, pops of an empty stack: %0d, peak use: %0d.",
               full_count, empty_count, peak_used);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
src/msp_pkg.sv
src/msp_ram.sv
src/multi_stack_shared_pool.sv
sim/stack_pool_checker.sv
sim/multi_stack_shared_pool_test.sv
